>>> rtl/assert_macros.svh
// Concurrent assertion helpers, sampled on clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsm assertion failed");

// Next-cycle implication.
`define BSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsm assertion failed");

`endif

>>> rtl/bsm_pkg.sv
`timescale 1ns / 1ps
package bsm_pkg;

  localparam int BASE_W  = 20;
  localparam int SPAN_W  = 9;
  localparam int SEL_W   = 4;
  localparam int PID_W   = 6;
  localparam int ADDR_W  = 32;
  localparam int OFF_W   = 8;
  localparam int FUNC_W  = 3;
  localparam int CMP_W   = 7;
  localparam logic [SPAN_W-1:0] MAX_SPAN = 9'd256;

  typedef enum logic [FUNC_W-1:0] {
    OP_LOOKUP   = 3'd0,
    OP_MAP      = 3'd1,
    OP_UNMAP    = 3'd2,
    OP_GET_PUB  = 3'd3,
    OP_GET_PRIV = 3'd4,
    OP_FREE     = 3'd5,
    OP_MARK     = 3'd6
  } op_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic pid_ok;
    logic found;
  } bsm_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] off;
  } bsm_take_t;

endpackage

>>> rtl/bsm_cell.sv
`timescale 1ns / 1ps
module bsm_cell #(
  parameter int NUM_PROCS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic                          d_mapped,
  input  logic                          d_priv,
  input  logic [NUM_PROCS-1:0]          d_mask,
  input  logic [bsm_pkg::BASE_W-1:0]    d_start,
  input  logic [bsm_pkg::SPAN_W-1:0]    d_span,
  output logic                          q_mapped,
  output logic                          q_priv,
  output logic [NUM_PROCS-1:0]          q_mask,
  output logic [bsm_pkg::BASE_W-1:0]    q_start,
  output logic [bsm_pkg::SPAN_W-1:0]    q_span
);
  import bsm_pkg::*;

  logic                 mapped_r;
  logic                 priv_r;
  logic [NUM_PROCS-1:0] mask_r;
  logic [BASE_W-1:0]    start_r;
  logic [SPAN_W-1:0]    span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r <= 1'b0;
      priv_r   <= 1'b0;
      mask_r   <= '0;
      start_r  <= '0;
      span_r   <= '0;
    end else if (shift_en) begin
      mapped_r <= d_mapped;
      priv_r   <= d_priv;
      mask_r   <= d_mask;
      start_r  <= d_start;
      span_r   <= d_span;
    end
  end

  assign q_mapped = mapped_r;
  assign q_priv   = priv_r;
  assign q_mask   = mask_r;
  assign q_start  = start_r;
  assign q_span   = span_r;

endmodule

>>> rtl/bsm_head.sv
`timescale 1ns / 1ps
module bsm_head #(
  parameter int NUM_PROCS = 64,
  parameter int VPN_W     = 20
) (
  input  bsm_pkg::bsm_ctl_t             ctl,
  input  logic [NUM_PROCS-1:0]          pbit,
  input  logic [VPN_W-1:0]              vpno,
  input  logic [bsm_pkg::BASE_W-1:0]    base,
  input  logic [bsm_pkg::SPAN_W-1:0]    cnt,
  input  logic                          e_mapped,
  input  logic                          e_priv,
  input  logic [NUM_PROCS-1:0]          e_mask,
  input  logic [bsm_pkg::BASE_W-1:0]    e_start,
  input  logic [bsm_pkg::SPAN_W-1:0]    e_span,
  output logic                          n_mapped,
  output logic                          n_priv,
  output logic [NUM_PROCS-1:0]          n_mask,
  output logic [bsm_pkg::BASE_W-1:0]    n_start,
  output logic [bsm_pkg::SPAN_W-1:0]    n_span,
  output bsm_pkg::bsm_take_t            take
);
  import bsm_pkg::*;

  localparam int RW = ((VPN_W > BASE_W + 1) ? VPN_W : BASE_W + 1) + 1;

  logic [RW-1:0] vpn_x;
  logic [RW-1:0] start_x;
  logic [RW-1:0] end_x;
  logic [RW-1:0] diff;
  logic          in_range;
  logic          one_user;

  assign vpn_x    = RW'(vpno);
  assign start_x  = RW'(e_start);
  assign end_x    = start_x + RW'(e_span);
  assign diff     = vpn_x - start_x;
  assign in_range = (vpn_x >= start_x) && (vpn_x < end_x);
  assign one_user = (e_mask != '0) && ((e_mask & (e_mask - NUM_PROCS'(1))) == '0);

  always_comb begin
    n_mapped = e_mapped;
    n_priv   = e_priv;
    n_mask   = e_mask;
    n_start  = e_start;
    n_span   = e_span;
    take     = '0;
    unique case (ctl.op)
      OP_LOOKUP: begin
        if (ctl.pid_ok && !ctl.found && e_mapped && ((e_mask & pbit) != '0) && in_range) begin
          take.hit = 1'b1;
          take.off = diff[OFF_W-1:0];
        end
      end
      OP_MAP: begin
        if (ctl.hit && ctl.pid_ok && !e_priv) begin
          n_mapped = 1'b1;
          n_priv   = 1'b0;
          n_mask   = e_mask | pbit;
          n_start  = base;
          n_span   = cnt;
          take.hit = 1'b1;
        end
      end
      OP_UNMAP: begin
        if (ctl.hit && ctl.pid_ok) begin
          if (e_priv || one_user) begin
            n_mapped = 1'b0;
            n_priv   = 1'b0;
            n_mask   = '0;
            n_start  = '0;
            n_span   = '0;
          end else begin
            n_mask = e_mask & ~pbit;
          end
          take.hit = 1'b1;
        end
      end
      OP_GET_PUB: begin
        if (!ctl.found && (!e_mapped || !e_priv)) begin
          take.hit = 1'b1;
        end
      end
      OP_GET_PRIV: begin
        if (!ctl.found && !e_mapped) begin
          take.hit = 1'b1;
        end
      end
      OP_FREE: begin
        if (ctl.hit) begin
          n_mapped = 1'b0;
          n_priv   = 1'b0;
          n_mask   = '0;
          n_start  = '0;
          n_span   = '0;
          take.hit = 1'b1;
        end
      end
      OP_MARK: begin
        if (ctl.hit) begin
          n_priv   = 1'b1;
          take.hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/backing_store_map_table_top.sv
`timescale 1ns / 1ps
// Backing-store map table: NUM_STORES entries held in a ring of cells.
// Input channel (in_valid/in_ready) takes one command word: func, proc_id,
// virt_addr, base_page, store_sel, page_count. Output channel
// (out_valid/out_ready) returns one result word per command: status,
// store_index, page_offset.
// A command rotates the ring once: every cycle the entry at the head cell is
// checked and rewritten, then passed to the tail, until every entry has been
// visited; the result register loads on the last step, or later if the
// output register is still full. A new command is taken only after the
// previous one has left the ring and its result is loaded.
// in_ready is high only while the ring is idle and aligned.
// If the receiver stalls, the finished result waits in the output register;
// a second command may run meanwhile and then holds until that word leaves.
// Synchronous reset clears every entry (unmapped, public, no users, zero
// range) and empties the output register.
module backing_store_map_table_top #(
  parameter int NUM_STORES = 16,
  parameter int NUM_PROCS  = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsm_pkg::FUNC_W-1:0]    in_func,
  input  logic [bsm_pkg::PID_W-1:0]     in_proc_id,
  input  logic [bsm_pkg::ADDR_W-1:0]    in_virt_addr,
  input  logic [bsm_pkg::BASE_W-1:0]    in_base_page,
  input  logic [bsm_pkg::SEL_W-1:0]     in_store_sel,
  input  logic [bsm_pkg::SPAN_W-1:0]    in_page_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [bsm_pkg::SEL_W-1:0]     out_store_index,
  output logic [bsm_pkg::OFF_W-1:0]     out_page_offset
);
  import bsm_pkg::*;
  `include "assert_macros.svh"

  localparam int IW    = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
  localparam int VPN_W = ADDR_W - $clog2(PAGE_BYTES);
  localparam logic [IW-1:0] LAST = IW'(NUM_STORES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [IW-1:0]        step_r;
  logic                 found_r;
  logic [IW-1:0]        res_idx_r;
  logic [OFF_W-1:0]     res_off_r;
  op_t                  op_r;
  logic [PID_W-1:0]     pid_r;
  logic [VPN_W-1:0]     vpno_r;
  logic [BASE_W-1:0]    base_r;
  logic [SEL_W-1:0]     sel_r;
  logic [SPAN_W-1:0]    cnt_r;
  logic                 out_valid_r;
  logic                 out_status_r;
  logic [SEL_W-1:0]     out_idx_r;
  logic [OFF_W-1:0]     out_off_r;

  logic                 in_fire;
  logic                 shift_en;
  logic                 out_free;
  logic                 finish;
  logic                 hit_now;
  logic                 res_found;
  logic [IW-1:0]        res_idx;
  logic [OFF_W-1:0]     res_off;
  logic [NUM_PROCS-1:0] pbit;
  bsm_ctl_t             ctl;
  bsm_take_t            take;

  logic                 c_mapped [NUM_STORES];
  logic                 c_priv   [NUM_STORES];
  logic [NUM_PROCS-1:0] c_mask   [NUM_STORES];
  logic [BASE_W-1:0]    c_start  [NUM_STORES];
  logic [SPAN_W-1:0]    c_span   [NUM_STORES];

  logic                 n_mapped;
  logic                 n_priv;
  logic [NUM_PROCS-1:0] n_mask;
  logic [BASE_W-1:0]    n_start;
  logic [SPAN_W-1:0]    n_span;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign shift_en  = (state_r == S_RUN);
  assign out_free  = !out_valid_r || out_ready;
  assign finish    = ((state_r == S_RUN) && (step_r == LAST)) || (state_r == S_HOLD);

  assign hit_now   = shift_en && take.hit;
  assign res_found = found_r || hit_now;
  assign res_idx   = hit_now ? step_r : res_idx_r;
  assign res_off   = hit_now ? take.off : res_off_r;

  assign pbit       = NUM_PROCS'(1) << pid_r;
  assign ctl.op     = op_r;
  assign ctl.hit    = (CMP_W'(step_r) == CMP_W'(sel_r));
  assign ctl.pid_ok = (CMP_W'(pid_r) < CMP_W'(NUM_PROCS));
  assign ctl.found  = found_r;

  generate
    for (genvar i = 0; i < NUM_STORES; i++) begin : g_ring
      if (i == NUM_STORES - 1) begin : g_tail
        bsm_cell #(.NUM_PROCS(NUM_PROCS)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
          .d_mapped(n_mapped), .d_priv(n_priv), .d_mask(n_mask),
          .d_start(n_start), .d_span(n_span),
          .q_mapped(c_mapped[i]), .q_priv(c_priv[i]), .q_mask(c_mask[i]),
          .q_start(c_start[i]), .q_span(c_span[i])
        );
      end else begin : g_mid
        bsm_cell #(.NUM_PROCS(NUM_PROCS)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
          .d_mapped(c_mapped[i+1]), .d_priv(c_priv[i+1]), .d_mask(c_mask[i+1]),
          .d_start(c_start[i+1]), .d_span(c_span[i+1]),
          .q_mapped(c_mapped[i]), .q_priv(c_priv[i]), .q_mask(c_mask[i]),
          .q_start(c_start[i]), .q_span(c_span[i])
        );
      end
    end
  endgenerate

  bsm_head #(.NUM_PROCS(NUM_PROCS), .VPN_W(VPN_W)) u_head (
    .ctl(ctl), .pbit(pbit), .vpno(vpno_r), .base(base_r), .cnt(cnt_r),
    .e_mapped(c_mapped[0]), .e_priv(c_priv[0]), .e_mask(c_mask[0]),
    .e_start(c_start[0]), .e_span(c_span[0]),
    .n_mapped(n_mapped), .n_priv(n_priv), .n_mask(n_mask),
    .n_start(n_start), .n_span(n_span), .take(take)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RUN;
      S_RUN: begin
        if (step_r == LAST) state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (shift_en) begin
        step_r <= (step_r == LAST) ? '0 : step_r + IW'(1);
      end
      if (finish && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= op_t'(in_func);
      pid_r     <= in_proc_id;
      vpno_r    <= in_virt_addr[ADDR_W-1 -: VPN_W];
      base_r    <= in_base_page;
      sel_r     <= in_store_sel;
      cnt_r     <= (in_page_count > MAX_SPAN) ? MAX_SPAN : in_page_count;
      found_r   <= 1'b0;
      res_idx_r <= '0;
      res_off_r <= '0;
    end else if (shift_en && take.hit) begin
      found_r   <= 1'b1;
      res_idx_r <= step_r;
      res_off_r <= take.off;
    end
    if (finish && out_free) begin
      out_status_r <= !res_found;
      out_idx_r    <= SEL_W'(res_idx);
      out_off_r    <= res_off;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_store_index = out_idx_r;
  assign out_page_offset = out_off_r;

  `BSM_ASSERT_NOW(a_idle_aligned, state_r == S_IDLE, step_r == '0)
  `BSM_ASSERT_NEXT(a_accept_runs, in_fire, (state_r == S_RUN) && (step_r == '0))
  `BSM_ASSERT_NEXT(a_stall_holds, (state_r == S_RUN) && (step_r == LAST) && !out_free,
                   state_r == S_HOLD)
  `BSM_ASSERT_NOW(a_ring_still, state_r != S_RUN, !shift_en)

endmodule
